// ----- rtl/row_span_trim_encoder_defines.svh -----
// Assertion macros shared by the row span trim encoder RTL.
// Included by modules that carry concurrent assertions; depends on nothing.
`ifndef ROW_SPAN_TRIM_ENCODER_DEFINES_SVH
`define ROW_SPAN_TRIM_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("row span trim encoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("row span trim encoder assertion failed");

`endif

// ----- rtl/rste_pkg.sv -----
// Package for the row span trim encoder: field widths, register indexes and the result type.
// Used by rste_cfg, rste_core and row_span_trim_encoder; depends on nothing.
package rste_pkg;

    localparam int PIXEL_W     = 32;
    localparam int ADDR_W      = 24;
    localparam int OFFSET_W    = 25;
    localparam int LEFT_W      = 12;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic                write_valid;
        logic [ADDR_W-1:0]   write_address;
        logic [PIXEL_W-1:0]  write_value;
        logic                header_valid;
        logic [ADDR_W-1:0]   row_start;
        logic [LEFT_W-1:0]   row_left;
        logic                row_empty;
        logic [OFFSET_W-1:0] next_start;
        logic                frame_last;
    } rste_result_t;

endpackage

// ----- rtl/rste_cfg.sv -----
// Configuration registers of the row span trim encoder, stored as clamped last indexes.
// Depends on rste_pkg.
module rste_cfg #(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rste_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rste_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [$clog2(MAX_COLS)-1:0]         col_last,
    output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] row_last
);
    import rste_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int EW = 18;
    localparam int RESET_COLS = (640 > MAX_COLS) ? MAX_COLS : 640;
    localparam int RESET_ROWS = (480 > MAX_ROWS) ? MAX_ROWS : 480;

    logic [CW-1:0] col_last_reg;
    logic [CW-1:0] col_last_next;
    logic [RW-1:0] row_last_reg;
    logic [RW-1:0] row_last_next;
    logic [EW-1:0] data_ext;
    logic [EW-1:0] col_clamped;
    logic [EW-1:0] row_clamped;

    assign cfg_ready = 1'b1;
    assign data_ext  = EW'(cfg_data);

    always_comb
    begin
        if (data_ext == '0)
        begin
            col_clamped = '0;
            row_clamped = '0;
        end
        else
        begin
            col_clamped = (data_ext > EW'(MAX_COLS)) ? EW'(MAX_COLS - 1) : data_ext - 1'b1;
            row_clamped = (data_ext > EW'(MAX_ROWS)) ? EW'(MAX_ROWS - 1) : data_ext - 1'b1;
        end
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_ROW_WIDTH)
            begin
                col_last_next = CW'(col_clamped);
            end
            else if (cfg_index == REG_FRAME_HEIGHT)
            begin
                row_last_next = RW'(row_clamped);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= CW'(RESET_COLS - 1);
            row_last_reg <= RW'(RESET_ROWS - 1);
        end
        else
        begin
            col_last_reg <= col_last_next;
            row_last_reg <= row_last_next;
        end
    end

    assign col_last = col_last_reg;
    assign row_last = row_last_reg;

endmodule

// ----- rtl/rste_core.sv -----
// Pixel datapath of the row span trim encoder: input register, span state and result register.
// Depends on rste_pkg and row_span_trim_encoder_defines.svh.
`include "row_span_trim_encoder_defines.svh"

module rste_core #(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [$clog2(MAX_COLS)-1:0]         col_last,
    input  logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] row_last,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic [rste_pkg::PIXEL_W-1:0]        pixel_bits,
    output logic                                result_valid,
    input  logic                                result_stall,
    output rste_pkg::rste_result_t              result
);
    import rste_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic               in_valid_reg;
    logic [PIXEL_W-1:0] pix_reg;
    logic               out_valid_reg;
    rste_result_t       res_reg;
    rste_result_t       res_next;

    logic [CW-1:0]       col_reg;
    logic [RW-1:0]       row_reg;
    logic [OFFSET_W-1:0] base_reg;
    logic                open_reg;
    logic [CW-1:0]       left_reg;
    logic [CW-1:0]       lastnz_reg;

    logic                advance;
    logic                nonzero;
    logic                open_now;
    logic [CW-1:0]       left_now;
    logic [CW-1:0]       lastnz_now;
    logic                row_end;
    logic                frame_end;
    logic [CW-1:0]       col_offset;
    logic [CW:0]         span_len;
    logic [OFFSET_W-1:0] next_base;

    assign advance     = in_valid_reg && (!out_valid_reg || !result_stall);
    assign pixel_stall = in_valid_reg && !advance;

    always_comb
    begin
        nonzero    = |pix_reg[PIXEL_W-2:0];
        open_now   = open_reg || nonzero;
        left_now   = open_reg ? left_reg : col_reg;
        lastnz_now = nonzero ? col_reg : lastnz_reg;
        row_end    = col_reg >= col_last;
        frame_end  = row_reg >= row_last;
        col_offset = col_reg - left_now;
        span_len   = {1'b0, lastnz_now} - {1'b0, left_now} + 1'b1;
        next_base  = open_now ? base_reg + OFFSET_W'(span_len) : base_reg;

        res_next = '0;
        if (open_now)
        begin
            res_next.write_valid   = 1'b1;
            res_next.write_address = base_reg[ADDR_W-1:0] + ADDR_W'(col_offset);
            res_next.write_value   = pix_reg;
        end
        if (row_end)
        begin
            res_next.header_valid = 1'b1;
            res_next.row_start    = base_reg[ADDR_W-1:0];
            res_next.row_left     = open_now ? LEFT_W'(left_now) : '0;
            res_next.row_empty    = !open_now;
            res_next.next_start   = next_base;
            res_next.frame_last   = frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= '0;
            open_reg      <= 1'b0;
            left_reg      <= '0;
            lastnz_reg    <= '0;
        end
        else
        begin
            if (!pixel_stall)
            begin
                in_valid_reg <= pixel_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (row_end)
                begin
                    base_reg   <= frame_end ? '0 : next_base;
                    row_reg    <= frame_end ? '0 : row_reg + 1'b1;
                    col_reg    <= '0;
                    open_reg   <= 1'b0;
                    left_reg   <= '0;
                    lastnz_reg <= '0;
                end
                else
                begin
                    col_reg    <= col_reg + 1'b1;
                    open_reg   <= open_now;
                    left_reg   <= left_now;
                    lastnz_reg <= lastnz_now;
                end
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!pixel_stall && pixel_valid)
        begin
            pix_reg <= pixel_bits;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = res_reg;

    `RSTE_ASSERT_IMPL(a_empty_row_header, clk, rst_n,
        out_valid_reg && res_reg.header_valid && res_reg.row_empty,
        !res_reg.write_valid && (res_reg.next_start == {1'b0, res_reg.row_start}))
    `RSTE_ASSERT_NEXT(a_frame_end_restart, clk, rst_n,
        advance && row_end && frame_end,
        (base_reg == '0) && (row_reg == '0) && (col_reg == '0))
    `RSTE_ASSERT_IMPL(a_span_order, clk, rst_n,
        open_reg,
        (left_reg <= lastnz_reg) && (lastnz_reg < col_reg))
    `RSTE_ASSERT_NEXT(a_drain_empties, clk, rst_n,
        out_valid_reg && !result_stall && !in_valid_reg,
        !out_valid_reg)

endmodule

// ----- rtl/row_span_trim_encoder.sv -----
// Top level of the row span trim encoder: configuration registers and pixel datapath.
// Depends on rste_pkg, rste_cfg and rste_core.
//
// The encoder takes one 32-bit pixel per transaction in raster order and presents one result
// per pixel from the result register, after the input register: a write into the packed data
// store from the row's first pixel with nonzero bits 30:0 on, and on a row's last pixel the row
// header. It sustains one pixel per clock unless result_stall holds a pending result. Row width
// and frame height are written at configuration port index 0 and 1; the user must write them
// only while the block is idle, which the block itself does not enforce. A value of 0 acts as 1
// and a value above MAX_COLS or MAX_ROWS acts as that maximum.
module row_span_trim_encoder #(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rste_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rste_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  logic [rste_pkg::PIXEL_W-1:0]      pixel_bits,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              write_valid,
    output logic [rste_pkg::ADDR_W-1:0]       write_address,
    output logic [rste_pkg::PIXEL_W-1:0]      write_value,
    output logic                              header_valid,
    output logic [rste_pkg::ADDR_W-1:0]       row_start,
    output logic [rste_pkg::LEFT_W-1:0]       row_left,
    output logic                              row_empty,
    output logic [rste_pkg::OFFSET_W-1:0]     next_start,
    output logic                              frame_last
);
    import rste_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [CW-1:0] col_last;
    logic [RW-1:0] row_last;
    rste_result_t  result;

    rste_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .col_last  (col_last),
        .row_last  (row_last)
    );

    rste_core #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .col_last     (col_last),
        .row_last     (row_last),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_bits   (pixel_bits),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign write_valid   = result.write_valid;
    assign write_address = result.write_address;
    assign write_value   = result.write_value;
    assign header_valid  = result.header_valid;
    assign row_start     = result.row_start;
    assign row_left      = result.row_left;
    assign row_empty     = result.row_empty;
    assign next_start    = result.next_start;
    assign frame_last    = result.frame_last;

endmodule
